### sv/spk_pkg.sv
// Shared types, constants and word functions for the 64-bit Speck cipher core.
// No dependencies; every other file in the block but spk_ram imports this package.
package spk_pkg;

   localparam int WORD_W             = 32;
   localparam int MAX_ROUNDS_DEFAULT = 32;
   localparam int CSR_IDX_W          = 3;
   localparam int KEY_LEN_W          = 5;
   localparam int ROUND_CNT_W        = 6;
   localparam int MAX_KEY_BYTES      = 16;
   localparam int LONG_KEY_BYTES     = 12;
   localparam int DEFAULT_ROUND_BASE = 23;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_KEY_WORD_0  = 3'd0,
      CSR_KEY_WORD_1  = 3'd1,
      CSR_KEY_WORD_2  = 3'd2,
      CSR_KEY_WORD_3  = 3'd3,
      CSR_KEY_LENGTH  = 3'd4,
      CSR_ROUND_COUNT = 3'd5
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXPAND,
      ST_PRIME,
      ST_RUN,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic load;
      logic shift;
   } cell_ctrl_type;

   typedef struct packed {
      logic load;
      logic step;
      logic decrypt;
   } round_ctrl_type;

   function automatic logic [WORD_W-1:0] rol3(input logic [WORD_W-1:0] w);
      return {w[WORD_W-4:0], w[WORD_W-1:WORD_W-3]};
   endfunction

   function automatic logic [WORD_W-1:0] ror3(input logic [WORD_W-1:0] w);
      return {w[2:0], w[WORD_W-1:3]};
   endfunction

   function automatic logic [WORD_W-1:0] rol8(input logic [WORD_W-1:0] w);
      return {w[WORD_W-9:0], w[WORD_W-1:WORD_W-8]};
   endfunction

   function automatic logic [WORD_W-1:0] ror8(input logic [WORD_W-1:0] w);
      return {w[7:0], w[WORD_W-1:8]};
   endfunction

   // Keep only the bytes of key word idx that fall inside the key length;
   // byte 0 sits in the most significant position.
   function automatic logic [WORD_W-1:0] mask_word(input logic [WORD_W-1:0] w,
                                                   input logic [1:0]        idx,
                                                   input logic [KEY_LEN_W-1:0] len);
      logic [WORD_W-1:0]    res;
      logic [KEY_LEN_W-1:0] pos;
      res = w;
      for (int b = 0; b < 4; b++) begin
         pos = {1'b0, idx, 2'b00} + KEY_LEN_W'(b);
         if (pos >= len) begin
            res[WORD_W-1-8*b -: 8] = 8'h00;
         end
      end
      return res;
   endfunction

endpackage

### sv/speck64_block_cipher_top.sv
// Channel  | Handshake             | Payload
// ---------+-----------------------+--------------------------------------------
// req      | req_valid / req_stall | req_kind, req_block_high, req_block_low
// rsp      | rsp_valid / rsp_stall | rsp_result_high, rsp_result_low
// csr      | csr_valid / csr_ready | csr_index, csr_wdata
//
// A block goes from acceptance through the prime state (primes the key RAM's
// registered read), the run state (one round per cycle in the single round unit
// for the round count in force) and the done state (loads the output register
// once no result waits under rsp_stall). After reset or a defined register write,
// the next block first expands round keys in the schedule cells, one key per cycle.
// Synchronous active-high reset resets control state and the configuration registers.
// A new request is taken while a result still waits under rsp_stall.
//
// Top level: register file, sequencer, schedule cells, round unit and key RAM.
// Depends on spk_pkg, spk_ram, spk_cell and spk_round.
module speck64_block_cipher_top #(
   parameter int MAX_ROUNDS = spk_pkg::MAX_ROUNDS_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic                            req_kind,
   input  logic [spk_pkg::WORD_W-1:0]      req_block_high,
   input  logic [spk_pkg::WORD_W-1:0]      req_block_low,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [spk_pkg::WORD_W-1:0]      rsp_result_high,
   output logic [spk_pkg::WORD_W-1:0]      rsp_result_low,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [spk_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [spk_pkg::WORD_W-1:0]      csr_wdata
);
   import spk_pkg::*;

   localparam int AW = $clog2(MAX_ROUNDS);
   localparam int RW = $clog2(MAX_ROUNDS + 1);

   // Configuration registers
   logic [WORD_W-1:0]      key_word_0_ff, key_word_1_ff, key_word_2_ff, key_word_3_ff;
   logic [KEY_LEN_W-1:0]   key_length_ff;
   logic [ROUND_CNT_W-1:0] round_count_ff;

   state_type         state_ff, state_in;
   logic              kind_ff, kind_in;
   logic [RW-1:0]     left_ff, left_in;
   logic [RW-1:0]     ecnt_ff, ecnt_in;
   logic [AW-1:0]     kidx_ff, kidx_in;
   logic [WORD_W-1:0] k_ff, k_in;
   logic              keys_expanded_ff, keys_expanded_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [WORD_W-1:0] rsp_result_high_ff, rsp_result_low_ff;

   logic                 accept, csr_we, csr_known;
   logic [KEY_LEN_W-1:0] eff_len;
   logic                 three_words;
   logic [4:0]           dflt_rounds;
   logic [6:0]           raw_rounds;
   logic [RW-1:0]        rounds_c;
   logic                 exp_last, out_load, ram_we;
   logic [WORD_W-1:0]    w0, w1, w2, w3;
   logic [WORD_W-1:0]    c0_word, c1_word, c2_word;
   logic [WORD_W-1:0]    c1_shift, new_l, new_k, ram_rdata, x_word, y_word;
   cell_ctrl_type        cell_ctrl;
   round_ctrl_type       rnd_ctrl;

   // Effective key length and round count
   always_comb begin
      eff_len     = (key_length_ff > KEY_LEN_W'(MAX_KEY_BYTES)) ?
                    KEY_LEN_W'(MAX_KEY_BYTES) : key_length_ff;
      three_words = eff_len > KEY_LEN_W'(LONG_KEY_BYTES);
      dflt_rounds = 5'(DEFAULT_ROUND_BASE) + 5'((eff_len + KEY_LEN_W'(3)) >> 2);
      raw_rounds  = (round_count_ff == '0) ? 7'(dflt_rounds) : 7'(round_count_ff);
      rounds_c    = (raw_rounds > 7'(MAX_ROUNDS)) ? RW'(MAX_ROUNDS) : RW'(raw_rounds);
   end

   // Masked key words and the schedule step
   always_comb begin
      w0       = mask_word(key_word_0_ff, 2'd0, eff_len);
      w1       = mask_word(key_word_1_ff, 2'd1, eff_len);
      w2       = mask_word(key_word_2_ff, 2'd2, eff_len);
      w3       = mask_word(key_word_3_ff, 2'd3, eff_len);
      new_l    = (ror8(c0_word) + k_ff) ^ WORD_W'(ecnt_ff);
      new_k    = rol3(k_ff) ^ new_l;
      c1_shift = three_words ? c2_word : new_l;
   end

   assign csr_ready = 1'b1;
   assign csr_we    = csr_valid && csr_ready;
   assign csr_known = csr_index <= CSR_ROUND_COUNT;
   assign req_stall = state_ff != ST_IDLE;
   assign accept    = req_valid && !req_stall;
   assign exp_last  = ecnt_ff == (rounds_c - RW'(1));

   // Sequencer: next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = keys_expanded_ff ? ST_PRIME : ST_EXPAND;
            end
         end
         ST_EXPAND: begin
            if (exp_last) begin
               state_in = ST_PRIME;
            end
         end
         ST_PRIME: state_in = ST_RUN;
         ST_RUN: begin
            if (left_ff == RW'(1)) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_load) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Sequencer: control outputs
   always_comb begin
      cell_ctrl.load   = accept;
      cell_ctrl.shift  = 1'b0;
      rnd_ctrl.load    = accept;
      rnd_ctrl.step    = 1'b0;
      rnd_ctrl.decrypt = kind_ff;
      ram_we           = 1'b0;
      out_load         = 1'b0;
      case (state_ff)
         ST_EXPAND: begin
            cell_ctrl.shift = 1'b1;
            ram_we          = 1'b1;
         end
         ST_RUN:  rnd_ctrl.step = 1'b1;
         ST_DONE: out_load = !rsp_valid_ff || !rsp_stall;
         default: ;
      endcase
   end

   // Datapath registers
   always_comb begin
      kind_in          = accept ? req_kind : kind_ff;
      left_in          = left_ff;
      ecnt_in          = ecnt_ff;
      kidx_in          = kidx_ff;
      k_in             = k_ff;
      keys_expanded_in = keys_expanded_ff;
      rsp_valid_in     = rsp_valid_ff;
      if (accept) begin
         left_in = rounds_c;
         ecnt_in = '0;
         kidx_in = req_kind ? AW'(rounds_c - RW'(1)) : '0;
         k_in    = three_words ? w3 : w2;
      end
      if (state_ff == ST_EXPAND) begin
         ecnt_in = ecnt_ff + RW'(1);
         k_in    = new_k;
         if (exp_last) begin
            keys_expanded_in = 1'b1;
         end
      end
      // Step the key read address, staying inside the expanded keys
      if (state_ff == ST_PRIME || state_ff == ST_RUN) begin
         if (!kind_ff && (RW'(kidx_ff) + RW'(1) < rounds_c)) begin
            kidx_in = kidx_ff + AW'(1);
         end else if (kind_ff && kidx_ff != '0) begin
            kidx_in = kidx_ff - AW'(1);
         end
      end
      if (state_ff == ST_RUN) begin
         left_in = left_ff - RW'(1);
      end
      if (csr_we && csr_known) begin
         keys_expanded_in = 1'b0;
      end
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= ST_IDLE;
         keys_expanded_ff <= 1'b0;
         rsp_valid_ff     <= 1'b0;
         key_word_0_ff    <= '0;
         key_word_1_ff    <= '0;
         key_word_2_ff    <= '0;
         key_word_3_ff    <= '0;
         key_length_ff    <= KEY_LEN_W'(MAX_KEY_BYTES);
         round_count_ff   <= '0;
      end else begin
         state_ff         <= state_in;
         keys_expanded_ff <= keys_expanded_in;
         rsp_valid_ff     <= rsp_valid_in;
         if (csr_we) begin
            case (csr_index)
               CSR_KEY_WORD_0:  key_word_0_ff  <= csr_wdata;
               CSR_KEY_WORD_1:  key_word_1_ff  <= csr_wdata;
               CSR_KEY_WORD_2:  key_word_2_ff  <= csr_wdata;
               CSR_KEY_WORD_3:  key_word_3_ff  <= csr_wdata;
               CSR_KEY_LENGTH:  key_length_ff  <= csr_wdata[KEY_LEN_W-1:0];
               CSR_ROUND_COUNT: round_count_ff <= csr_wdata[ROUND_CNT_W-1:0];
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      kind_ff <= kind_in;
      left_ff <= left_in;
      ecnt_ff <= ecnt_in;
      kidx_ff <= kidx_in;
      k_ff    <= k_in;
      if (out_load) begin
         rsp_result_high_ff <= x_word;
         rsp_result_low_ff  <= y_word;
      end
   end

   // Schedule word cells: head feeds the step, new word enters at the tail
   spk_cell u_cell0 (
      .clock      (clock),
      .ctrl       (cell_ctrl),
      .load_word  (three_words ? w2 : w1),
      .shift_word (c1_word),
      .word       (c0_word)
   );

   spk_cell u_cell1 (
      .clock      (clock),
      .ctrl       (cell_ctrl),
      .load_word  (three_words ? w1 : w0),
      .shift_word (c1_shift),
      .word       (c1_word)
   );

   spk_cell u_cell2 (
      .clock      (clock),
      .ctrl       (cell_ctrl),
      .load_word  (w0),
      .shift_word (new_l),
      .word       (c2_word)
   );

   spk_ram #(
      .WIDTH (WORD_W),
      .DEPTH (MAX_ROUNDS)
   ) u_key_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ecnt_ff[AW-1:0]),
      .wdata (k_ff),
      .raddr (kidx_ff),
      .rdata (ram_rdata)
   );

   spk_round u_round (
      .clock     (clock),
      .ctrl      (rnd_ctrl),
      .load_x    (req_block_high),
      .load_y    (req_block_low),
      .round_key (ram_rdata),
      .x         (x_word),
      .y         (y_word)
   );

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_result_high = rsp_result_high_ff;
   assign rsp_result_low  = rsp_result_low_ff;

`ifndef ASSERT_OFF
   a_prime_needs_keys: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_PRIME |-> keys_expanded_ff)
      else $error("round key read started before expansion finished");

   a_run_has_rounds: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_RUN |-> left_ff != '0)
      else $error("round unit stepping with no rounds left");

   a_key_index_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_PRIME || state_ff == ST_RUN) |-> RW'(kidx_ff) < rounds_c)
      else $error("key read address beyond expanded keys");

   a_done_from_run: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE && $past(state_ff) != ST_DONE) |-> $past(state_ff) == ST_RUN)
      else $error("result completed without running rounds");
`endif

endmodule

### sv/spk_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing; holds the expanded round keys.
module spk_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

### sv/spk_cell.sv
// One key schedule word cell: loads a key word or takes its neighbour's word.
// Depends on spk_pkg for the cell control struct and word width.
module spk_cell (
   input  logic                         clock,
   input  spk_pkg::cell_ctrl_type       ctrl,
   input  logic [spk_pkg::WORD_W-1:0]   load_word,
   input  logic [spk_pkg::WORD_W-1:0]   shift_word,
   output logic [spk_pkg::WORD_W-1:0]   word
);
   import spk_pkg::*;

   logic [WORD_W-1:0] word_ff;
   logic [WORD_W-1:0] word_in;

   always_comb begin
      word_in = word_ff;
      if (ctrl.load) begin
         word_in = load_word;
      end else if (ctrl.shift) begin
         word_in = shift_word;
      end
   end

   always_ff @(posedge clock) begin
      word_ff <= word_in;
   end

   assign word = word_ff;

endmodule

### sv/spk_round.sv
// Block state and one Speck round per cycle while ctrl.step is set, forward or inverse.
// Depends on spk_pkg for rotations and the round control struct.
module spk_round (
   input  logic                         clock,
   input  spk_pkg::round_ctrl_type      ctrl,
   input  logic [spk_pkg::WORD_W-1:0]   load_x,
   input  logic [spk_pkg::WORD_W-1:0]   load_y,
   input  logic [spk_pkg::WORD_W-1:0]   round_key,
   output logic [spk_pkg::WORD_W-1:0]   x,
   output logic [spk_pkg::WORD_W-1:0]   y
);
   import spk_pkg::*;

   logic [WORD_W-1:0] x_ff, x_in;
   logic [WORD_W-1:0] y_ff, y_in;
   logic [WORD_W-1:0] enc_x, enc_y, dec_x, dec_y;

   always_comb begin
      enc_x = (ror8(x_ff) + y_ff) ^ round_key;
      enc_y = rol3(y_ff) ^ enc_x;
      dec_y = ror3(y_ff ^ x_ff);
      dec_x = rol8((x_ff ^ round_key) - dec_y);
   end

   always_comb begin
      x_in = x_ff;
      y_in = y_ff;
      if (ctrl.load) begin
         x_in = load_x;
         y_in = load_y;
      end else if (ctrl.step) begin
         x_in = ctrl.decrypt ? dec_x : enc_x;
         y_in = ctrl.decrypt ? dec_y : enc_y;
      end
   end

   always_ff @(posedge clock) begin
      x_ff <= x_in;
      y_ff <= y_in;
   end

   assign x = x_ff;
   assign y = y_ff;

endmodule

### tb/sv/tb.sv
`timescale 1ns / 1ps
// Self-checking bench for the 64-bit Speck cipher core: writes the key registers,
// streams blocks in both directions and checks every output block in order.
// Depends on spk_pkg and speck64_block_cipher_top.
module tb;
   import spk_pkg::*;

   localparam int PERIOD      = 20;
   localparam int MAX_ROUNDS  = MAX_ROUNDS_DEFAULT;
   localparam int CYCLE_LIMIT = 400000;
   localparam int HOLD_CYCLES = 150;
   localparam int SETTLE      = 2 * MAX_ROUNDS + 8;

   localparam logic KIND_ENCRYPT = 1'b0;
   localparam logic KIND_DECRYPT = 1'b1;

   // indexes past the end of the register list
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_LOW  = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_HIGH = 3'd7;

   typedef logic [WORD_W-1:0] word_type;
   typedef struct packed {
      word_type high;
      word_type low;
   } block_type;

   logic                 clock          = 1'b0;
   logic                 reset          = 1'b1;
   logic                 req_valid      = 1'b0;
   logic                 req_stall;
   logic                 req_kind       = KIND_ENCRYPT;
   word_type             req_block_high = '0;
   word_type             req_block_low  = '0;
   logic                 rsp_valid;
   logic                 rsp_stall      = 1'b0;
   word_type             rsp_result_high;
   word_type             rsp_result_low;
   logic                 csr_valid      = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index      = '0;
   word_type             csr_wdata      = '0;

   // cipher state mirrored in the bench
   word_type               key_reg [4]  = '{default: '0};
   logic [KEY_LEN_W-1:0]   key_len_reg  = KEY_LEN_W'(MAX_KEY_BYTES);
   logic [ROUND_CNT_W-1:0] round_cnt_reg = '0;
   word_type               round_keys [MAX_ROUNDS];
   bit                     keys_ready   = 1'b0;
   block_type              expected_blocks [$];

   block_type last_cipher;
   bit        have_cipher  = 1'b0;
   bit        req_idle_on  = 1'b1;
   bit        rsp_idle_on  = 1'b1;
   int        hold_ticket  = 0;
   int        failures     = 0;
   int        cycle_count  = 0;

   speck64_block_cipher_top DUT (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_kind        (req_kind),
      .req_block_high  (req_block_high),
      .req_block_low   (req_block_low),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_result_high (rsp_result_high),
      .rsp_result_low  (rsp_result_low),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   always #(PERIOD / 2) clock = ~clock;

   function automatic word_type rotr(word_type v, int n);
      return (v >> n) | (v << (WORD_W - n));
   endfunction

   function automatic word_type rotl(word_type v, int n);
      return (v << n) | (v >> (WORD_W - n));
   endfunction

   function automatic int key_bytes_used();
      return (key_len_reg > MAX_KEY_BYTES) ? MAX_KEY_BYTES : int'(key_len_reg);
   endfunction

   function automatic int rounds_in_force();
      int r;
      r = round_cnt_reg;
      if (r == 0) r = DEFAULT_ROUND_BASE + ((key_bytes_used() + 3) >> 2);
      if (r > MAX_ROUNDS) r = MAX_ROUNDS;
      return r;
   endfunction

   function automatic void expand_round_keys();
      int       len;
      int       rounds;
      int       m;
      int       s;
      int       left;
      word_type kw [4];
      word_type kept;
      len    = key_bytes_used();
      rounds = rounds_in_force();
      m      = (len > LONG_KEY_BYTES) ? 3 : 2;
      kw     = '{default: '0};
      for (int i = 0; i <= m; i++) begin
         // zero the bytes past the key length, byte 0 at the top
         left = len - 4 * i;
         kept = key_reg[i];
         if (left <= 0) kept = '0;
         else if (left < 4) kept = kept & ~(32'hFFFF_FFFF >> (left * 8));
         kw[m - i] = kept;
      end
      round_keys[0] = kw[0];
      for (int i = 0; i + 1 < rounds; i++) begin
         s = (i % m) + 1;
         kw[s] = (rotr(kw[s], 8) + kw[0]) ^ word_type'(i);
         kw[0] = rotl(kw[0], 3) ^ kw[s];
         round_keys[i + 1] = kw[0];
      end
      keys_ready = 1'b1;
   endfunction

   function automatic block_type cipher_block(logic kind, block_type din);
      block_type d;
      int        rounds;
      if (!keys_ready) expand_round_keys();
      rounds = rounds_in_force();
      d = din;
      if (kind == KIND_ENCRYPT) begin
         for (int i = 0; i < rounds; i++) begin
            d.high = (rotr(d.high, 8) + d.low) ^ round_keys[i];
            d.low  = rotl(d.low, 3) ^ d.high;
         end
      end else begin
         for (int i = rounds; i > 0; i--) begin
            d.low  = rotr(d.low ^ d.high, 3);
            d.high = rotl((d.high ^ round_keys[i - 1]) - d.low, 8);
         end
      end
      return d;
   endfunction

   function automatic void apply_csr(logic [CSR_IDX_W-1:0] idx, word_type data);
      case (idx)
         CSR_KEY_WORD_0:  key_reg[0] = data;
         CSR_KEY_WORD_1:  key_reg[1] = data;
         CSR_KEY_WORD_2:  key_reg[2] = data;
         CSR_KEY_WORD_3:  key_reg[3] = data;
         CSR_KEY_LENGTH:  key_len_reg = data[KEY_LEN_W-1:0];
         CSR_ROUND_COUNT: round_cnt_reg = data[ROUND_CNT_W-1:0];
         default: return;
      endcase
      keys_ready = 1'b0;
   endfunction

   function automatic word_type pick_word();
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return '1;
         2:       return 32'h8000_0000;
         3:       return 32'h0000_0001;
         default: return $urandom;
      endcase
   endfunction

   task automatic send_block(logic kind, word_type high, word_type low);
      block_type din;
      block_type res;
      int        gap;
      din = {high, low};
      @(negedge clock);
      if (req_idle_on && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 3);
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid      <= 1'b1;
      req_kind       <= kind;
      req_block_high <= high;
      req_block_low  <= low;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      res = cipher_block(kind, din);
      expected_blocks.push_back(res);
      if (kind == KIND_ENCRYPT) begin
         last_cipher = res;
         have_cipher = 1'b1;
      end
   endtask

   // Drop the request and wait until every expected block has come back.
   task automatic drain_results();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_blocks.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Call only once the core has drained.
   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, word_type data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      apply_csr(idx, data);
      have_cipher = 1'b0;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic test_reset_key();
      send_block(KIND_ENCRYPT, '0, '0);
      send_block(KIND_ENCRYPT, '1, '1);
      send_block(KIND_DECRYPT, '0, '1);
   endtask

   task automatic test_known_vector();
      drain_results();
      write_csr(CSR_KEY_WORD_0, 32'h1b1a_1918);
      write_csr(CSR_KEY_WORD_1, 32'h1312_1110);
      write_csr(CSR_KEY_WORD_2, 32'h0b0a_0908);
      write_csr(CSR_KEY_WORD_3, 32'h0302_0100);
      write_csr(CSR_KEY_LENGTH, 32'd16);
      write_csr(CSR_ROUND_COUNT, 32'd0);
      send_block(KIND_ENCRYPT, 32'h3b72_6574, 32'h7475_432d);
      send_block(KIND_DECRYPT, 32'h8c6f_a548, 32'h454e_028b);
   endtask

   task automatic test_key_lengths();
      int lens [5];
      lens = '{0, 5, 12, 13, 31};
      foreach (lens[i]) begin
         drain_results();
         write_csr(CSR_KEY_LENGTH, word_type'(lens[i]));
         send_block((i % 2 == 0) ? KIND_ENCRYPT : KIND_DECRYPT, 32'h8000_0000, 32'h0000_0001);
      end
   endtask

   task automatic test_round_counts();
      drain_results();
      write_csr(CSR_ROUND_COUNT, 32'd1);
      send_block(KIND_ENCRYPT, 32'hdead_beef, '1);
      send_block(KIND_DECRYPT, '1, 32'h0123_4567);
      drain_results();
      write_csr(CSR_ROUND_COUNT, word_type'(MAX_ROUNDS));
      send_block(KIND_ENCRYPT, 32'h5555_5555, 32'haaaa_aaaa);
      drain_results();
      write_csr(CSR_ROUND_COUNT, 32'hFFFF_FFFF);
      send_block(KIND_DECRYPT, 32'haaaa_aaaa, 32'h5555_5555);
      drain_results();
      write_csr(CSR_ROUND_COUNT, 32'd0);
   endtask

   // Writes past the register list must leave the expanded keys alone.
   task automatic test_spare_index();
      send_block(KIND_ENCRYPT, 32'h0f0f_0f0f, 32'hf0f0_f0f0);
      drain_results();
      write_csr(CSR_SPARE_LOW, '1);
      send_block(KIND_DECRYPT, 32'h0f0f_0f0f, 32'hf0f0_f0f0);
      drain_results();
      write_csr(CSR_SPARE_HIGH, 32'h1234_5678);
      send_block(KIND_ENCRYPT, '1, '0);
   endtask

   task automatic test_random_phases(int phases, int items);
      word_type data;
      for (int p = 0; p < phases; p++) begin
         drain_results();
         for (int r = CSR_KEY_WORD_0; r <= CSR_ROUND_COUNT; r++) begin
            if ($urandom_range(0, 1) == 0) continue;
            data = pick_word();
            if (r == CSR_KEY_LENGTH) begin
               data[KEY_LEN_W-1:0] = ($urandom_range(0, 4) == 0) ?
                                     KEY_LEN_W'($urandom_range(17, 31)) :
                                     KEY_LEN_W'($urandom_range(0, 16));
               if ($urandom_range(0, 1) == 0) data[WORD_W-1:KEY_LEN_W] = '0;
            end else if (r == CSR_ROUND_COUNT) begin
               case ($urandom_range(0, 4))
                  0, 1:    data[ROUND_CNT_W-1:0] = '0;
                  2:       data[ROUND_CNT_W-1:0] = ROUND_CNT_W'($urandom_range(33, 63));
                  default: data[ROUND_CNT_W-1:0] = ROUND_CNT_W'($urandom_range(1, 32));
               endcase
               if ($urandom_range(0, 1) == 0) data[WORD_W-1:ROUND_CNT_W] = '0;
            end
            write_csr(r[CSR_IDX_W-1:0], data);
         end
         if ($urandom_range(0, 5) == 0) write_csr(CSR_SPARE_LOW, $urandom);
         req_idle_on = ($urandom_range(0, 3) != 0);
         rsp_idle_on = ($urandom_range(0, 3) != 0);
         for (int i = 0; i < items; i++) begin
            // mostly fresh blocks, now and then undo the last encryption
            if (have_cipher && $urandom_range(0, 4) == 0)
               send_block(KIND_DECRYPT, last_cipher.high, last_cipher.low);
            else
               send_block(logic'($urandom_range(0, 1)), pick_word(), pick_word());
         end
      end
   endtask

   task automatic test_backpressure();
      req_idle_on = 1'b1;
      rsp_idle_on = 1'b1;
      hold_ticket++;
      for (int i = 0; i < 10; i++)
         send_block(logic'($urandom_range(0, 1)), $urandom, $urandom);
      drain_results();
      for (int i = 0; i < 5; i++)
         send_block(logic'($urandom_range(0, 1)), $urandom, $urandom);
   endtask

   task automatic test_quiet_tail(int items);
      req_idle_on = 1'b0;
      rsp_idle_on = 1'b0;
      for (int i = 0; i < items; i++)
         send_block(logic'($urandom_range(0, 1)), $urandom, $urandom);
   endtask

   // Receiver side: short random stalls, plus one long hold when asked.
   initial begin : drive_rsp_stall
      int burst_left;
      int hold_left;
      int hold_seen;
      burst_left = 0;
      hold_left  = 0;
      hold_seen  = 0;
      forever begin
         @(negedge clock);
         if (hold_ticket != hold_seen) begin
            hold_seen = hold_ticket;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (burst_left > 0) begin
            burst_left--;
            rsp_stall <= 1'b1;
         end else if (rsp_idle_on && $urandom_range(0, 3) == 0) begin
            burst_left = $urandom_range(0, 2);
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin : check_results
      block_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_blocks.size() == 0) begin
            $display("%0t: result with none expected: high %h low %h",
                     $time, rsp_result_high, rsp_result_low);
            failures++;
         end else begin
            want = expected_blocks.pop_front();
            if (rsp_result_high !== want.high) begin
               $display("%0t: result_high mismatch: expected %h, actual %h",
                        $time, want.high, rsp_result_high);
               failures++;
            end
            if (rsp_result_low !== want.low) begin
               $display("%0t: result_low mismatch: expected %h, actual %h",
                        $time, want.low, rsp_result_low);
               failures++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   initial begin
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_reset_key();
      test_known_vector();
      test_key_lengths();
      test_round_counts();
      test_spare_index();
      test_random_phases(8, 60);
      test_backpressure();
      test_quiet_tail(40);
      drain_results();
      repeat (SETTLE) @(posedge clock);
      if (expected_blocks.size() != 0) begin
         $display("%0t: %0d expected results never arrived", $time, expected_blocks.size());
         failures++;
      end
      if (failures == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

### filelist.f
sv/spk_pkg.sv
sv/spk_ram.sv
sv/spk_cell.sv
sv/spk_round.sv
sv/speck64_block_cipher_top.sv
tb/sv/tb.sv
